// ----- src/cixv_pkg.sv -----
package cixv_pkg;

  localparam int BYTE_W     = 8;
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam int POS_W      = 6;

  // register index, taken from paddr[2]
  localparam logic REG_DIRECTION = 1'b0;

  localparam logic DIR_DECODE = 1'b0;
  localparam logic DIR_ENCODE = 1'b1;

  localparam logic [POS_W-1:0] POS_FIRST = 6'd6;
  localparam logic [POS_W-1:0] POS_SAT   = 6'd63;
  localparam logic [POS_W:0]   POS_STEP  = 7'd7;

  typedef struct packed {
    logic take;
    logic step;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic dec_final;
    logic enc_more;
    logic rem_more;
  } sts_t;

endpackage

// ----- src/cixv_dp.sv -----
module cixv_dp #(
  parameter int VALUE_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         direction,
  input  logic [cixv_pkg::BYTE_W-1:0]  in_byte,
  input  logic [VALUE_BITS-1:0]        in_value,
  input  cixv_pkg::cmd_t               cmd,
  output cixv_pkg::sts_t               sts,
  output logic                         is_value,
  output logic [cixv_pkg::BYTE_W-1:0]  out_byte,
  output logic [VALUE_BITS-1:0]        out_value,
  output logic                         last
);

  logic [VALUE_BITS-1:0]          acc;
  logic [cixv_pkg::POS_W-1:0]     bit_position;
  logic                           negative_flag;
  logic                           in_continuation;
  logic [VALUE_BITS-1:0]          rem;

  logic                           neg_in;
  logic [VALUE_BITS-1:0]          mag;
  logic [cixv_pkg::BYTE_W-1:0]    first_byte;
  logic [cixv_pkg::BYTE_W-1:0]    step_byte;
  logic [VALUE_BITS+6:0]          grp_shift;
  logic [VALUE_BITS-1:0]          acc_or;
  logic [cixv_pkg::POS_W:0]       pos_sum;
  logic [cixv_pkg::POS_W-1:0]     pos_next;
  logic [VALUE_BITS-1:0]          acc_new;
  logic                           neg_new;
  logic                           dec_final;
  logic [VALUE_BITS-1:0]          dec_value;

  // encode side
  assign neg_in       = in_value[VALUE_BITS-1];
  assign mag          = neg_in ? (~in_value + 1'b1) : in_value;
  assign sts.enc_more = |mag[VALUE_BITS-1:6];
  assign first_byte   = {neg_in, sts.enc_more, mag[5:0]};
  assign sts.rem_more = |rem[VALUE_BITS-1:7];
  assign step_byte    = {sts.rem_more, rem[6:0]};

  // decode side
  assign grp_shift = {{VALUE_BITS{1'b0}}, in_byte[6:0]} << bit_position;
  assign acc_or    = (bit_position != cixv_pkg::POS_SAT) ?
                     (acc | grp_shift[VALUE_BITS-1:0]) : acc;
  assign pos_sum   = {1'b0, bit_position} + cixv_pkg::POS_STEP;
  assign pos_next  = pos_sum[cixv_pkg::POS_W] ? cixv_pkg::POS_SAT
                                              : pos_sum[cixv_pkg::POS_W-1:0];

  always_comb begin
    if (!in_continuation) begin
      acc_new   = VALUE_BITS'(in_byte[5:0]);
      neg_new   = in_byte[7];
      dec_final = !in_byte[6];
    end else begin
      acc_new   = acc_or;
      neg_new   = negative_flag;
      dec_final = !in_byte[7];
    end
  end

  assign sts.dec_final = dec_final;
  assign dec_value     = neg_new ? (~acc_new + 1'b1) : acc_new;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc             <= '0;
      bit_position    <= '0;
      negative_flag   <= 1'b0;
      in_continuation <= 1'b0;
    end else if (cmd.take && direction == cixv_pkg::DIR_DECODE) begin
      acc             <= acc_new;
      negative_flag   <= neg_new;
      bit_position    <= in_continuation ? pos_next : cixv_pkg::POS_FIRST;
      in_continuation <= !dec_final;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      rem <= rem >> 7;
    end else if (cmd.take && direction == cixv_pkg::DIR_ENCODE) begin
      rem <= mag >> 6;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      if (cmd.step) begin
        is_value  <= 1'b0;
        out_byte  <= step_byte;
        out_value <= '0;
        last      <= !sts.rem_more;
      end else if (direction == cixv_pkg::DIR_ENCODE) begin
        is_value  <= 1'b0;
        out_byte  <= first_byte;
        out_value <= '0;
        last      <= !sts.enc_more;
      end else begin
        is_value  <= 1'b1;
        out_byte  <= '0;
        out_value <= dec_value;
        last      <= 1'b1;
      end
    end
  end

endmodule

// ----- src/cixv_ctrl.sv -----
module cixv_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           direction,
  input  logic           s_tvalid,
  output logic           s_tready,
  output logic           m_tvalid,
  input  logic           m_tready,
  input  cixv_pkg::sts_t sts,
  output cixv_pkg::cmd_t cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_ENC  = 1'b1;

  logic state;
  logic state_next;
  logic m_tvalid_next;
  logic out_free;

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == ST_IDLE) && out_free;

  assign cmd.take = s_tvalid && s_tready;
  assign cmd.step = (state == ST_ENC) && out_free;
  assign cmd.load = (cmd.take && (direction == cixv_pkg::DIR_ENCODE || sts.dec_final))
                    || cmd.step;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd.take && direction == cixv_pkg::DIR_ENCODE && sts.enc_more) begin
          state_next = ST_ENC;
        end
      end
      ST_ENC: begin
        if (cmd.step && !sts.rem_more) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.load) begin
      m_tvalid_next = 1'b1;
    end else if (out_free) begin
      m_tvalid_next = 1'b0;
    end else begin
      m_tvalid_next = m_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      m_tvalid <= m_tvalid_next;
    end
  end

  a_no_take_over_held_beat: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> (!m_tvalid || m_tready))
    else $error("input taken while a result beat is held");

  a_enc_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ENC) |-> !s_tready)
    else $error("input ready during an encode run");

  a_step_presents_beat: assert property (@(posedge clk) disable iff (rst)
    cmd.step |=> m_tvalid)
    else $error("encode step left no beat");

  a_run_ends: assert property (@(posedge clk) disable iff (rst)
    (cmd.step && !sts.rem_more) |=> (state == ST_IDLE))
    else $error("encode run did not end on its last byte");

endmodule

// ----- src/compact_index_varint_codec.sv -----
// Compact index varint codec. With direction = 1 each signed input value becomes
// a run of 1 to 1 + ceil((VALUE_BITS - 6) / 7) bytes (5 at the default width),
// first byte {sign, continue, mag[5:0]}, later bytes {continue, 7 magnitude bits},
// tlast on the final byte. One byte leaves per cycle while m_tready is high,
// through a single output register; the next value is taken once the last byte
// of the run is loaded. With direction = 0 one byte is taken per cycle while the
// output register is free, and a decoded value (tuser high, tlast high) follows
// the byte without a continuation flag; magnitude bits beyond VALUE_BITS are
// dropped and negation wraps. Switching direction keeps a partly decoded value.
module compact_index_varint_codec #(
  parameter int VALUE_BITS = 32
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // APB
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [cixv_pkg::APB_ADDR_W-1:0]        paddr,
  input  logic [cixv_pkg::APB_DATA_W-1:0]        pwdata,
  output logic [cixv_pkg::APB_DATA_W-1:0]        prdata,
  output logic                                   pready,
  // input stream
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  input  logic [((8+VALUE_BITS+7)/8)*8-1:0]      s_tdata, // in_byte, in_value
  // output stream
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  output logic [((8+VALUE_BITS+7)/8)*8-1:0]      m_tdata, // out_byte, out_value
  output logic                                   m_tuser, // is_value
  output logic                                   m_tlast
);

  localparam int TDATA_W = ((8 + VALUE_BITS + 7) / 8) * 8;

  logic                          direction;
  logic                          cfg_write;
  cixv_pkg::cmd_t                cmd;
  cixv_pkg::sts_t                sts;
  logic [cixv_pkg::BYTE_W-1:0]   out_byte;
  logic [VALUE_BITS-1:0]         out_value;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready &&
                     (paddr[2] == cixv_pkg::REG_DIRECTION);
  assign prdata    = (paddr[2] == cixv_pkg::REG_DIRECTION) ?
                     cixv_pkg::APB_DATA_W'(direction) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      direction <= cixv_pkg::DIR_DECODE;
    end else if (cfg_write) begin
      direction <= pwdata[0];
    end
  end

  cixv_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .direction (direction),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  cixv_dp #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .direction (direction),
    .in_byte   (s_tdata[cixv_pkg::BYTE_W-1:0]),
    .in_value  (s_tdata[cixv_pkg::BYTE_W +: VALUE_BITS]),
    .cmd       (cmd),
    .sts       (sts),
    .is_value  (m_tuser),
    .out_byte  (out_byte),
    .out_value (out_value),
    .last      (m_tlast)
  );

  assign m_tdata = TDATA_W'({out_value, out_byte});

endmodule

// ----- tb/compact_index_varint_codec_tb.sv -----
module compact_index_varint_codec_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VALUE_W     = 32;
  localparam int DATA_W      = ((cixv_pkg::BYTE_W + VALUE_W + 7) / 8) * 8;
  localparam int HOLD_CYCLES = 8;
  localparam int QUIET_LIMIT = 2000;
  localparam logic [cixv_pkg::APB_ADDR_W-1:0] REG_ADDR = {cixv_pkg::REG_DIRECTION, 2'b00};

  typedef struct packed {
    logic                        is_value;
    logic [cixv_pkg::BYTE_W-1:0] out_byte;
    logic [VALUE_W-1:0]          out_value;
    logic                        last;
  } out_beat_t;

  logic                            clk      = 1'b0;
  logic                            rst      = 1'b1;
  logic                            psel     = 1'b0;
  logic                            penable  = 1'b0;
  logic                            pwrite   = 1'b0;
  logic [cixv_pkg::APB_ADDR_W-1:0] paddr    = '0;
  logic [cixv_pkg::APB_DATA_W-1:0] pwdata   = '0;
  logic [cixv_pkg::APB_DATA_W-1:0] prdata;
  logic                            pready;
  logic                            s_tvalid = 1'b0;
  logic                            s_tready;
  logic [DATA_W-1:0]               s_tdata  = '0; // in_byte, in_value
  logic                            m_tvalid;
  logic                            m_tready = 1'b0;
  logic [DATA_W-1:0]               m_tdata;       // out_byte, out_value
  logic                            m_tuser;       // is_value
  logic                            m_tlast;

  out_beat_t                   due_beats[$];
  logic [cixv_pkg::BYTE_W-1:0] run_bytes[$];
  logic                        cur_dir     = cixv_pkg::DIR_DECODE;
  logic [VALUE_W-1:0]          dec_mag     = '0;
  int                          dec_pos     = 0;
  logic                        dec_neg     = 1'b0;
  logic                        dec_cont    = 1'b0;
  int                          send_idle_pct = 32;
  int                          recv_idle_pct = 45;
  int                          fails       = 0;
  int                          quiet       = 0;

  compact_index_varint_codec u_top (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #6 clk = ~clk;

  // Byte run of one value: sign/continue/6 bits first, then 7-bit groups.
  function automatic void encode_run(input logic [VALUE_W-1:0] x);
    logic [VALUE_W-1:0]          v;
    logic [cixv_pkg::BYTE_W-1:0] b;
    run_bytes.delete();
    v = x;
    b = 8'h00;
    if (v[VALUE_W-1]) begin
      v = '0 - v;
      b = 8'h80;
    end
    b[5:0] = v[5:0];
    if (v > 32'h3F) b[6] = 1'b1;
    run_bytes.push_back(b);
    v = v >> 6;
    while (v != 0) begin
      b = {1'b0, v[6:0]};
      v = v >> 7;
      if (v != 0) b[7] = 1'b1;
      run_bytes.push_back(b);
    end
  endfunction

  // Accumulate one encoded byte; queue the value once its run ends.
  function automatic void fold_byte(input logic [cixv_pkg::BYTE_W-1:0] b);
    logic [63:0] grp;
    out_beat_t   r;
    if (!dec_cont) begin
      dec_neg = b[7];
      dec_mag = {{(VALUE_W-6){1'b0}}, b[5:0]};
      dec_pos = 6;
      if (b[6]) begin
        dec_cont = 1'b1;
        return;
      end
    end else begin
      grp = {57'd0, b[6:0]} << dec_pos;
      if (dec_pos < VALUE_W) dec_mag = dec_mag | grp[VALUE_W-1:0];
      dec_pos = (dec_pos + 7 > 63) ? 63 : dec_pos + 7;
      if (b[7]) return;
    end
    dec_cont    = 1'b0;
    r.is_value  = 1'b1;
    r.out_byte  = '0;
    r.out_value = dec_neg ? ('0 - dec_mag) : dec_mag;
    r.last      = 1'b1;
    due_beats.push_back(r);
  endfunction

  function automatic logic [VALUE_W-1:0] rand_value();
    logic [VALUE_W-1:0] mag;
    mag = $urandom & ((32'd1 << $urandom_range(31, 1)) - 32'd1);
    return $urandom_range(1) ? ('0 - mag) : mag;
  endfunction

  function automatic logic [cixv_pkg::BYTE_W-1:0] rand_byte();
    logic [31:0] r;
    r = $urandom;
    return r[cixv_pkg::BYTE_W-1:0];
  endfunction

  task automatic send_item(input logic [cixv_pkg::BYTE_W-1:0] b,
                           input logic [VALUE_W-1:0] v);
    out_beat_t beat;
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {v, b};
    do @(posedge clk); while (!s_tready);
    if (cur_dir == cixv_pkg::DIR_ENCODE) begin
      encode_run(v);
      foreach (run_bytes[i]) begin
        beat.is_value  = 1'b0;
        beat.out_byte  = run_bytes[i];
        beat.out_value = '0;
        beat.last      = (i == run_bytes.size() - 1);
        due_beats.push_back(beat);
      end
    end else begin
      fold_byte(b);
    end
    @(negedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic [cixv_pkg::APB_ADDR_W-1:0] addr,
                            input logic [cixv_pkg::APB_DATA_W-1:0] wdata,
                            output logic [cixv_pkg::APB_DATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
  endtask

  // Drain, hold, then write the direction and read it back.
  task automatic config_direction(input logic d);
    logic [cixv_pkg::APB_DATA_W-1:0] rd;
    s_tvalid <= 1'b0;
    while (due_beats.size() != 0) @(negedge clk);
    repeat (HOLD_CYCLES) @(negedge clk);
    apb_access(1'b1, REG_ADDR, {{(cixv_pkg::APB_DATA_W-1){1'b0}}, d}, rd);
    cur_dir = d;
    apb_access(1'b0, REG_ADDR, '0, rd);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (rd[0] !== d) begin
      $error("direction: expected %0d, got %0d", d, rd[0]);
      fails++;
    end
  endtask

  task automatic test_decode_directed();
    config_direction(cixv_pkg::DIR_DECODE);
    send_item(8'h00, $urandom);
    send_item(8'h3F, $urandom);
    send_item(8'hBF, $urandom);
    send_item(8'h80, $urandom);
    // overlong run: groups past the value width, position saturating
    send_item(8'hFF, $urandom);
    repeat (9) send_item(8'hFF, $urandom);
    send_item(8'h7F, $urandom);
  endtask

  task automatic test_encode_directed();
    config_direction(cixv_pkg::DIR_ENCODE);
    send_item(rand_byte(), 32'd0);
    send_item(rand_byte(), 32'd63);
    send_item(rand_byte(), -32'sd63);
    send_item(rand_byte(), 32'd64);
    send_item(rand_byte(), -32'sd64);
    send_item(rand_byte(), 32'h7FFF_FFFF);
    send_item(rand_byte(), 32'h8000_0001);
    send_item(rand_byte(), 32'd8192);
  endtask

  task automatic test_resume_after_switch();
    config_direction(cixv_pkg::DIR_DECODE);
    send_item(8'h41, $urandom);
    config_direction(cixv_pkg::DIR_ENCODE);
    send_item(rand_byte(), -32'sd5000);
    config_direction(cixv_pkg::DIR_DECODE);
    send_item(8'h05, $urandom);
  endtask

  task automatic test_random(input int sp, input int rp, input int n_items);
    int                          sent;
    int                          chunk;
    int                          k;
    logic [cixv_pkg::BYTE_W-1:0] seq[$];
    send_idle_pct = sp;
    recv_idle_pct = rp;
    sent = 0;
    while (sent < n_items) begin
      chunk = $urandom_range(14, 6);
      if ($urandom_range(1)) begin
        config_direction(cixv_pkg::DIR_ENCODE);
        repeat (chunk) send_item(rand_byte(), rand_value());
        sent += chunk;
      end else begin
        config_direction(cixv_pkg::DIR_DECODE);
        k = 0;
        while (k < chunk) begin
          if ($urandom_range(4) == 0) begin
            send_item(rand_byte(), $urandom);
            k++;
          end else begin
            encode_run(rand_value());
            seq = run_bytes;
            // leave a run open now and then so it may straddle a switch
            if (seq.size() > 1 && $urandom_range(5) == 0) void'(seq.pop_back());
            foreach (seq[i]) send_item(seq[i], $urandom);
            k += seq.size();
          end
        end
        sent += k;
      end
    end
  endtask

  always @(negedge clk) m_tready <= ($urandom_range(99) >= recv_idle_pct);

  always @(posedge clk) begin : chk
    out_beat_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (due_beats.size() == 0) begin
        $error("unexpected beat: tdata %h tuser %b tlast %b", m_tdata, m_tuser, m_tlast);
        fails++;
      end else begin
        want = due_beats.pop_front();
        if (m_tuser !== want.is_value) begin
          $error("is_value: expected %0d, got %0d", want.is_value, m_tuser);
          fails++;
        end
        if (m_tdata[cixv_pkg::BYTE_W-1:0] !== want.out_byte) begin
          $error("out_byte: expected %h, got %h", want.out_byte,
                 m_tdata[cixv_pkg::BYTE_W-1:0]);
          fails++;
        end
        if (m_tdata[cixv_pkg::BYTE_W+VALUE_W-1:cixv_pkg::BYTE_W] !== want.out_value) begin
          $error("out_value: expected %0d, got %0d", $signed(want.out_value),
                 $signed(m_tdata[cixv_pkg::BYTE_W+VALUE_W-1:cixv_pkg::BYTE_W]));
          fails++;
        end
        if (m_tlast !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, m_tlast);
          fails++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
      quiet <= 0;
    end else if (quiet + 1 >= QUIET_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_decode_directed();
    test_encode_directed();
    test_resume_after_switch();
    test_random(32, 45, 44);
    test_random(45, 32, 44);
    test_random(0, 0, 44);
    s_tvalid <= 1'b0;
    while (due_beats.size() != 0) @(posedge clk);
    repeat (2 * HOLD_CYCLES) @(posedge clk);
    if (fails == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
